// ----- rtl/tsl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the TVD slope limiter.
package tsl_pkg;

  // Default fraction bits of the signed fixed-point format
  localparam int FRAC_BITS_DEF = 16;

  // Integer bits of the saturated slope ratio (ratio limit is 2^15 - 1)
  localparam int RINT_BITS = 15;

  // All five cells wet
  localparam logic [4:0] WET_ALL = 5'h1F;

  // Limiter selection
  typedef enum logic [1:0] {
    MODE_ZERO       = 2'd0,
    MODE_VAN_LEER   = 2'd1,
    MODE_SUPERBEE   = 2'd2,
    MODE_VAN_ALBADA = 2'd3
  } mode_t;

  localparam mode_t MODE_RESET = MODE_VAN_LEER;

  // Side information that rides along the first divider
  typedef struct packed {
    logic               zero;
    logic               a_neg;
    logic               sgn_diff;
    logic               ovf;
    mode_t              mode;
    logic signed [32:0] sum;
  } tag1_t;

  // Side information that rides along the second divider
  typedef struct packed {
    logic               zero;
    logic               a_neg;
    logic               phi_neg;
    logic               direct;
    mode_t              mode;
    logic signed [32:0] sum;
    logic [32:0]        vlq;
  } tag2_t;

endpackage

// ----- rtl/tsl_divider.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, with a tag carried alongside.
module tsl_divider #(
  parameter int NW = 64,
  parameter int DW = 33,
  parameter int QW = 33,
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] in_n,
  input  logic [DW-1:0] in_d,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [QW-1:0] out_q,
  output logic [TW-1:0] out_tag
);

  // Stage registers
  logic [DW-1:0] r_st [QW];
  logic [QW-1:0] n_st [QW];
  logic [DW-1:0] d_st [QW];
  logic [QW-1:0] q_st [QW];
  logic [TW-1:0] t_st [QW];
  logic [QW-1:0] v_st;

  // Stage sources
  logic [DW-1:0] r_src [QW];
  logic [QW-1:0] n_src [QW];
  logic [DW-1:0] d_src [QW];
  logic [QW-1:0] q_src [QW];
  logic [TW-1:0] t_src [QW];
  logic [QW-1:0] v_src;

  // Next values
  logic [DW-1:0] r_next [QW];
  logic [QW-1:0] n_next [QW];
  logic [QW-1:0] q_next [QW];

  // Stage 0 takes the high dividend bits as its partial remainder
  always_comb begin
    r_src[0] = DW'(in_n >> QW);
    n_src[0] = in_n[QW-1:0];
    d_src[0] = in_d;
    q_src[0] = '0;
    t_src[0] = in_tag;
    v_src[0] = in_valid;
    for (int s = 1; s < QW; s++) begin
      r_src[s] = r_st[s-1];
      n_src[s] = n_st[s-1];
      d_src[s] = d_st[s-1];
      q_src[s] = q_st[s-1];
      t_src[s] = t_st[s-1];
      v_src[s] = v_st[s-1];
    end
  end

  // One trial subtract per stage
  always_comb begin
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;
    for (int s = 0; s < QW; s++) begin
      trial     = {r_src[s], n_src[s][QW-1]};
      diff      = trial - {1'b0, d_src[s]};
      ge        = (trial >= {1'b0, d_src[s]});
      r_next[s] = ge ? diff[DW-1:0] : trial[DW-1:0];
      n_next[s] = n_src[s] << 1;
      q_next[s] = {q_src[s][QW-2:0], ge};
    end
  end

  // Valid bits clear on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      v_st <= '0;
    end else begin
      v_st <= v_src;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    for (int s = 0; s < QW; s++) begin
      r_st[s] <= r_next[s];
      n_st[s] <= n_next[s];
      d_st[s] <= d_src[s];
      q_st[s] <= q_next[s];
      t_st[s] <= t_src[s];
    end
  end

  assign out_valid = v_st[QW-1];
  assign out_q     = q_st[QW-1];
  assign out_tag   = t_st[QW-1];

endmodule

// ----- rtl/tvd_slope_limiter_unit.sv -----
`timescale 1ns / 1ps
// Path from start to done: stages 1 and 2, the bit-per-stage divider for the ratio or
//   van Leer quotient, stages 3 to 5, the bit-per-stage phi divider, stage 6, output register.
// Throughput: one item per clock; busy stays low, the receiver cannot stall.
// Reset (rst, synchronous): clears all pipeline valid bits and sets limiter_mode
//   to van Leer; no clearing pass, the block takes items on the first cycle after.
// Top level of the TVD slope limiter unit.
module tvd_slope_limiter_unit #(
  parameter int FRAC_BITS = tsl_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] slope_left,
  input  logic signed [31:0] slope_right,
  input  logic [4:0]         wet_mask,
  output logic               done,
  output logic signed [31:0] limited_slope
);

  localparam int RW  = FRAC_BITS + tsl_pkg::RINT_BITS;
  localparam int Q1W = (RW > 33) ? RW : 33;
  localparam int N1W = 64;
  localparam int D1W = 33;
  localparam int SQW = 2 * RW - FRAC_BITS;
  localparam int D2W = FRAC_BITS + 31;
  localparam int N2W = 2 * FRAC_BITS + 31;
  localparam int Q2W = FRAC_BITS + 1;
  localparam int PW  = Q2W + 33;
  localparam int TW1 = $bits(tsl_pkg::tag1_t);
  localparam int TW2 = $bits(tsl_pkg::tag2_t) + Q2W;
  localparam int LAT = Q1W + FRAC_BITS + 8;

  localparam logic [Q1W-1:0] RMAX1 =
    Q1W'((64'(1) << tsl_pkg::RINT_BITS) - 64'(1)) << FRAC_BITS;
  localparam logic [RW-1:0]  ONE_R  = RW'(1) << FRAC_BITS;
  localparam logic [RW-1:0]  HALF_R = RW'(1) << (FRAC_BITS - 1);
  localparam logic [D2W-1:0] ONE_D2 = D2W'(1) << FRAC_BITS;
  localparam logic [N2W-1:0] TWO_N2 = N2W'(1) << (2 * FRAC_BITS + 1);

  tsl_pkg::mode_t limiter_mode;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      limiter_mode <= tsl_pkg::MODE_RESET;
    end else if (cfg_we) begin
      limiter_mode <= tsl_pkg::mode_t'(cfg_data);
    end
  end

  assign busy = 1'b0;

  // ---------------- Stage 1: magnitudes, product, flags ----------------
  logic          s1_valid;
  logic [63:0]   s1_prod;
  logic [31:0]   s1_ma;
  logic [31:0]   s1_mb;
  tsl_pkg::tag1_t s1_tag;

  logic [31:0]    ma;
  logic [31:0]    mb;
  tsl_pkg::tag1_t tag1_in;

  always_comb begin
    ma = slope_left[31]  ? (~slope_left + 32'd1)  : slope_left;
    mb = slope_right[31] ? (~slope_right + 32'd1) : slope_right;
    tag1_in.a_neg    = slope_left[31];
    tag1_in.sgn_diff = slope_left[31] ^ slope_right[31];
    tag1_in.mode     = limiter_mode;
    tag1_in.sum      = {slope_left[31], slope_left} + {slope_right[31], slope_right};
    // ratio overflows once |b| >= |a| * 2^RINT_BITS
    tag1_in.ovf      = ({15'd0, mb} >= ({ma, 15'd0} >> (15 - tsl_pkg::RINT_BITS)));
    tag1_in.zero     = (wet_mask != tsl_pkg::WET_ALL) ||
                       (limiter_mode == tsl_pkg::MODE_ZERO) ||
                       (slope_left == 32'sd0) ||
                       ((limiter_mode == tsl_pkg::MODE_VAN_LEER) &&
                        ((slope_right == 32'sd0) || tag1_in.sgn_diff));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_prod <= 64'(ma) * 64'(mb);
    s1_ma   <= ma;
    s1_mb   <= mb;
    s1_tag  <= tag1_in;
  end

  // ---------------- Stage 2: first divider operands ----------------
  logic           s2_valid;
  logic [N1W-1:0] s2_n;
  logic [D1W-1:0] s2_d;
  tsl_pkg::tag1_t s2_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    if (s1_tag.mode == tsl_pkg::MODE_VAN_LEER) begin
      s2_n <= s1_prod << 1;
      s2_d <= 33'(s1_ma) + 33'(s1_mb);
    end else begin
      s2_n <= N1W'(s1_mb) << FRAC_BITS;
      s2_d <= 33'(s1_ma);
    end
    s2_tag <= s1_tag;
  end

  // ---------------- Divider 1: van Leer quotient or ratio ----------------
  logic           d1_valid;
  logic [Q1W-1:0] d1_q;
  logic [TW1-1:0] d1_tag;
  tsl_pkg::tag1_t d1_info;

  tsl_divider #(
    .NW (N1W),
    .DW (D1W),
    .QW (Q1W),
    .TW (TW1)
  ) u_div_ratio (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_n      (s2_n),
    .in_d      (s2_d),
    .in_tag    (s2_tag),
    .out_valid (d1_valid),
    .out_q     (d1_q),
    .out_tag   (d1_tag)
  );

  assign d1_info = d1_tag;

  // ---------------- Stage 3: ratio saturation ----------------
  logic           s3_valid;
  logic [RW-1:0]  s3_m;
  logic           s3_rneg;
  logic [32:0]    s3_vlq;
  tsl_pkg::tag1_t s3_tag;

  logic [RW-1:0] m_sat;

  assign m_sat = (d1_info.ovf || (d1_q > RMAX1)) ? RMAX1[RW-1:0] : d1_q[RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= d1_valid;
    end
    s3_m    <= m_sat;
    s3_rneg <= d1_info.sgn_diff && (m_sat != '0);
    s3_vlq  <= d1_q[32:0];
    s3_tag  <= d1_info;
  end

  // ---------------- Stage 4: ratio squared ----------------
  logic            s4_valid;
  logic [2*RW-1:0] s4_sqf;
  logic [RW-1:0]   s4_m;
  logic            s4_rneg;
  logic [32:0]     s4_vlq;
  tsl_pkg::tag1_t  s4_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_sqf  <= (2*RW)'(s3_m) * (2*RW)'(s3_m);
    s4_m    <= s3_m;
    s4_rneg <= s3_rneg;
    s4_vlq  <= s3_vlq;
    s4_tag  <= s3_tag;
  end

  // ---------------- Stage 5: phi operands ----------------
  logic           s5_valid;
  logic [N2W-1:0] s5_n;
  logic [D2W-1:0] s5_d;
  logic [TW2-1:0] s5_tag;

  logic [SQW-1:0]  sq;
  logic [D2W-1:0]  magnum;
  logic [N2W-1:0]  n2;
  logic [D2W-1:0]  d2;
  logic [Q2W-1:0]  dphi;
  tsl_pkg::tag2_t  tag2_in;

  assign sq = s4_sqf[2*RW-1:FRAC_BITS];

  always_comb begin
    tag2_in.zero    = s4_tag.zero;
    tag2_in.a_neg   = s4_tag.a_neg;
    tag2_in.mode    = s4_tag.mode;
    tag2_in.sum     = s4_tag.sum;
    tag2_in.vlq     = s4_vlq;
    tag2_in.phi_neg = 1'b0;
    tag2_in.direct  = 1'b0;
    dphi            = '0;
    magnum          = '0;
    n2              = '0;
    d2              = ONE_D2;
    if (s4_tag.mode == tsl_pkg::MODE_SUPERBEE) begin
      // phi known without a divide below r = 1
      if (s4_rneg) begin
        tag2_in.direct = 1'b1;
      end else if (s4_m < HALF_R) begin
        tag2_in.direct = 1'b1;
        dphi           = Q2W'(s4_m) << 1;
      end else if (s4_m < ONE_R) begin
        tag2_in.direct = 1'b1;
        dphi           = Q2W'(ONE_R);
      end else begin
        n2 = TWO_N2;
        d2 = D2W'(s4_m) + ONE_D2;
      end
    end else if (s4_tag.mode == tsl_pkg::MODE_VAN_ALBADA) begin
      // numerator r*r + r, kept as sign and magnitude
      if (s4_rneg) begin
        if (D2W'(s4_m) > D2W'(sq)) begin
          magnum          = D2W'(s4_m) - D2W'(sq);
          tag2_in.phi_neg = 1'b1;
        end else begin
          magnum = D2W'(sq) - D2W'(s4_m);
        end
      end else begin
        magnum = D2W'(sq) + D2W'(s4_m);
      end
      n2 = N2W'(magnum) << FRAC_BITS;
      d2 = D2W'(sq) + ONE_D2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5_n   <= n2;
    s5_d   <= d2;
    s5_tag <= {tag2_in, dphi};
  end

  // ---------------- Divider 2: phi ----------------
  logic           d2_valid;
  logic [Q2W-1:0] d2_q;
  logic [TW2-1:0] d2_tag;
  tsl_pkg::tag2_t d2_info;
  logic [Q2W-1:0] d2_dphi;

  tsl_divider #(
    .NW (N2W),
    .DW (D2W),
    .QW (Q2W),
    .TW (TW2)
  ) u_div_phi (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s5_valid),
    .in_n      (s5_n),
    .in_d      (s5_d),
    .in_tag    (s5_tag),
    .out_valid (d2_valid),
    .out_q     (d2_q),
    .out_tag   (d2_tag)
  );

  assign d2_info = d2_tag[TW2-1:Q2W];
  assign d2_dphi = d2_tag[Q2W-1:0];

  // ---------------- Stage 6: phi times |a + b| ----------------
  logic           s6_valid;
  logic [PW-1:0]  s6_prod;
  logic           s6_neg;
  logic [32:0]    s6_vlq;
  logic           s6_a_neg;
  tsl_pkg::mode_t s6_mode;
  logic           s6_zero;

  logic [Q2W-1:0] phi;
  logic [32:0]    abs_sum;

  assign phi     = d2_info.direct ? d2_dphi : d2_q;
  assign abs_sum = d2_info.sum[32] ? (~d2_info.sum + 33'd1) : d2_info.sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= d2_valid;
    end
    s6_prod  <= PW'(phi) * PW'(abs_sum);
    s6_neg   <= d2_info.phi_neg ^ d2_info.sum[32];
    s6_vlq   <= d2_info.vlq;
    s6_a_neg <= d2_info.a_neg;
    s6_mode  <= d2_info.mode;
    s6_zero  <= d2_info.zero;
  end

  // ---------------- Stage 7: sign, saturation, output register ----------------
  logic [32:0] mag;
  logic        neg;
  logic [31:0] result;

  always_comb begin
    if (s6_mode == tsl_pkg::MODE_VAN_LEER) begin
      mag = s6_vlq;
      neg = s6_a_neg;
    end else begin
      mag = 33'(s6_prod >> (FRAC_BITS + 1));
      neg = s6_neg;
    end
    if (s6_zero) begin
      result = 32'd0;
    end else if (!neg) begin
      result = (mag[32] || mag[31]) ? 32'h7FFF_FFFF : mag[31:0];
    end else begin
      result = (mag > 33'h0_8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s6_valid;
    end
    limited_slope <= result;
  end

`ifndef ASSERT_OFF
  // every accepted item produces a result on done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result missing after fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##LAT !done)
    else $error("result without an accepted item");

  // a dry neighbor forces a zero slope
  a_dry_zero: assert property (@(posedge clk) disable iff (rst)
    (start && (wet_mask != tsl_pkg::WET_ALL)) |-> ##LAT (limited_slope == 32'sd0))
    else $error("dry cell did not give zero");

  // mode zero gives a zero slope
  a_mode_zero: assert property (@(posedge clk) disable iff (rst)
    (start && (limiter_mode == tsl_pkg::MODE_ZERO)) |-> ##LAT (limited_slope == 32'sd0))
    else $error("mode zero did not give zero");
`endif

endmodule
